/* sv/scar_pkg.sv */
// ----------------------------------------------------------------------------
// scar_pkg: shared types, constants and helpers for the stereo reverb
// Sample formats, preset room table and saturation used by lanes and top.
// ----------------------------------------------------------------------------
`default_nettype none

package scar_pkg;

    localparam int IW      = 24;   // internal sample width, Q15
    localparam int WORK_AW = 14;   // work store address width
    localparam int DIFF_AW = 11;   // diffuser store address width
    localparam int TAP_W   = 13;
    localparam int AP_W    = 11;
    localparam int GAIN_W  = 16;

    localparam logic signed [47:0] SMP_MAX = (48'sd1 <<< (IW - 1)) - 48'sd1;
    localparam logic signed [47:0] SMP_MIN = -(48'sd1 <<< (IW - 1));

    typedef logic signed [IW-1:0] smp_t;

    typedef struct packed {
        logic [TAP_W-1:0]  tap0;
        logic [TAP_W-1:0]  tap1;
        logic [TAP_W-1:0]  tap2;
        logic [TAP_W-1:0]  tap3;
        logic [AP_W-1:0]   ap1;
        logic [AP_W-1:0]   ap2;
        logic [GAIN_W-1:0] wall;
    } row_t;

    // clearing pass control, shared by both lanes
    typedef struct packed {
        logic               active;
        logic [WORK_AW-1:0] addr;
    } clr_t;

    // lane status toward the top
    typedef struct packed {
        logic busy;
        logic done;
    } lane_st_t;

    function automatic row_t row_lookup(input logic [2:0] sel);
        row_t r;
        case (sel)
            3'd0:    r = '{13'd1500, 13'd1600, 13'd1700, 13'd1800, 11'd500,  11'd400,  16'd39322};
            3'd1:    r = '{13'd1200, 13'd1300, 13'd1400, 13'd1500, 11'd400,  11'd300,  16'd32768};
            3'd2:    r = '{13'd2000, 13'd2200, 13'd2400, 13'd2600, 11'd600,  11'd500,  16'd42598};
            3'd3:    r = '{13'd3000, 13'd3300, 13'd3600, 13'd3900, 11'd800,  11'd700,  16'd45875};
            3'd4:    r = '{13'd4000, 13'd4400, 13'd4800, 13'd5200, 11'd1000, 11'd900,  16'd49152};
            default: r = '{13'd5500, 13'd6000, 13'd6500, 13'd7000, 11'd1200, 11'd1100, 16'd52429};
        endcase
        return r;
    endfunction

    function automatic smp_t sat_iw(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v;
        if (v > SMP_MAX) t = SMP_MAX;
        if (v < SMP_MIN) t = SMP_MIN;
        return t[IW-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/scar_lane.sv */
// ----------------------------------------------------------------------------
// scar_lane: one channel of the reverb core
// Lowpass, four comb taps from the work store, two allpass diffusers and
// the decayed write-back; eight steps per frame on one store read port,
// then a handover in the wait state before the next frame starts.
// ----------------------------------------------------------------------------
`default_nettype none

module scar_lane
    import scar_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire clr_t                      clr,
    input  wire logic                      start,
    input  wire logic                      take,
    input  wire logic signed [15:0]        dry_in,
    input  wire logic [WORK_AW-1:0]        pos,
    input  wire row_t                      row,
    input  wire logic [GAIN_W-1:0]         eff_wall,
    output lane_st_t                       st,
    output smp_t                           wet,
    output logic signed [15:0]             dry_out
);

    localparam logic [2:0] STEP_COMB  = 3'd4;
    localparam logic [2:0] STEP_AP2   = 3'd5;
    localparam logic [2:0] STEP_MUL   = 3'd6;
    localparam logic [2:0] STEP_WRITE = 3'd7;

    smp_t work_mem [2**WORK_AW];
    smp_t ap1_mem  [2**DIFF_AW];
    smp_t ap2_mem  [2**DIFF_AW];

    logic [2:0]               step_reg;
    logic                     run_reg;
    logic                     wait_reg;
    logic [WORK_AW-1:0]       pos_reg;
    row_t                     row_reg;
    logic [GAIN_W-1:0]        eff_reg;
    logic signed [15:0]       dry_reg;
    smp_t                     lp_reg;
    smp_t                     filt_reg;
    smp_t                     wrd_reg;
    smp_t                     d1_reg;
    smp_t                     d2_reg;
    logic signed [IW+1:0]     sum_reg;
    smp_t                     out1_reg;
    smp_t                     wet_reg;
    logic signed [IW+16:0]    prod_reg;

    logic [TAP_W-1:0]         tap_sel;
    logic [WORK_AW-1:0]       rd_addr;
    logic [DIFF_AW-1:0]       di;
    logic [DIFF_AW-1:0]       d1_addr;
    logic [DIFF_AW-1:0]       d2_addr;
    logic signed [IW:0]       lp_sum;
    smp_t                     filt_next;
    logic signed [IW+1:0]     wrd_ext;
    logic signed [IW+1:0]     sum_all;
    smp_t                     comb;
    smp_t                     out1_next;
    smp_t                     ap1_new;
    smp_t                     out2_next;
    smp_t                     ap2_new;
    smp_t                     work_new;

    // pick the comb tap for this step
    always_comb begin
        case (step_reg[1:0])
            2'd0:    tap_sel = row_reg.tap0;
            2'd1:    tap_sel = row_reg.tap1;
            2'd2:    tap_sel = row_reg.tap2;
            default: tap_sel = row_reg.tap3;
        endcase
    end

    assign rd_addr = pos_reg - WORK_AW'(tap_sel);
    assign di      = pos_reg[DIFF_AW-1:0];
    assign d1_addr = di - row_reg.ap1;
    assign d2_addr = di - row_reg.ap2;

    // lowpass with coefficient one half, floor rounding
    assign lp_sum    = (IW+1)'(lp_reg) + (IW+1)'(dry_in);
    assign filt_next = lp_sum[IW:1];

    // comb average and first allpass
    assign wrd_ext   = (IW+2)'(wrd_reg);
    assign sum_all   = sum_reg + wrd_ext;
    assign comb      = sum_all[IW+1:2];
    assign out1_next = sat_iw(48'(d1_reg) - 48'(comb));
    assign ap1_new   = sat_iw(48'(comb) + 48'(d1_reg >>> 1));

    // second allpass
    assign out2_next = sat_iw(48'(d2_reg) - 48'(out1_reg));
    assign ap2_new   = sat_iw(48'(out1_reg) + 48'(d2_reg >>> 1));

    // decayed feedback into the work store
    assign work_new  = sat_iw(48'(filt_reg) + 48'(prod_reg >>> 16));

    // sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            wait_reg <= 1'b0;
            step_reg <= '0;
            lp_reg   <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            wait_reg <= 1'b0;
            step_reg <= '0;
            lp_reg   <= filt_next;
        end else if (run_reg) begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == STEP_WRITE) begin
                run_reg  <= 1'b0;
                wait_reg <= 1'b1;
            end
        end else if (take) begin
            wait_reg <= 1'b0;
        end
    end

    // latch frame context and run the datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            pos_reg  <= pos;
            row_reg  <= row;
            eff_reg  <= eff_wall;
            dry_reg  <= dry_in;
            filt_reg <= filt_next;
        end
        if (run_reg) begin
            case (step_reg)
                3'd1:       sum_reg  <= wrd_ext;
                3'd2, 3'd3: sum_reg  <= sum_reg + wrd_ext;
                STEP_COMB:  out1_reg <= out1_next;
                STEP_AP2:   wet_reg  <= out2_next;
                STEP_MUL:   prod_reg <= wet_reg * $signed({1'b0, eff_reg});
                default:    ;
            endcase
        end
    end

    // work store: one read, one write or clear per cycle
    always_ff @(posedge aclk) begin
        wrd_reg <= work_mem[rd_addr];
        if (clr.active) begin
            work_mem[clr.addr] <= '0;
        end else if (run_reg && step_reg == STEP_WRITE) begin
            work_mem[pos_reg] <= work_new;
        end
    end

    // first diffuser
    always_ff @(posedge aclk) begin
        d1_reg <= ap1_mem[d1_addr];
        if (clr.active) begin
            ap1_mem[clr.addr[DIFF_AW-1:0]] <= '0;
        end else if (run_reg && step_reg == STEP_COMB) begin
            ap1_mem[di] <= ap1_new;
        end
    end

    // second diffuser
    always_ff @(posedge aclk) begin
        d2_reg <= ap2_mem[d2_addr];
        if (clr.active) begin
            ap2_mem[clr.addr[DIFF_AW-1:0]] <= '0;
        end else if (run_reg && step_reg == STEP_AP2) begin
            ap2_mem[di] <= ap2_new;
        end
    end

    assign st.busy = run_reg | wait_reg;
    assign st.done = wait_reg;
    assign wet     = wet_reg;
    assign dry_out = dry_reg;

endmodule

`default_nettype wire

/* sv/scar_mix.sv */
// ----------------------------------------------------------------------------
// scar_mix: dry/wet merge of both lanes
// Mixes, clamps to full scale and scales by 32767 over a stalling pipeline
// that ends in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scar_mix
    import scar_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] dry_l,
    input  wire logic signed [15:0] dry_r,
    input  wire smp_t               wet_l,
    input  wire smp_t               wet_r,
    input  wire logic               last_in,
    input  wire logic [16:0]        mix,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_left,
    output logic signed [15:0]      m_out_right,
    output logic                    m_block_end
);

    localparam logic signed [IW+18:0] ACC_MAX = (43'sd1 <<< 31);
    localparam logic signed [IW+18:0] ACC_MIN = -(43'sd1 <<< 31);

    logic                     en;
    logic                     v1_reg, v2_reg, v3_reg, ov_reg;
    logic                     l1_reg, l2_reg, l3_reg, lo_reg;
    logic signed [33:0]       pd_reg [2];
    logic signed [IW+17:0]    pw_reg [2];
    logic [31:0]              mag_reg [2];
    logic                     n2_reg [2];
    logic [15:0]              sc_reg [2];
    logic                     n3_reg [2];
    logic signed [15:0]       out_reg [2];

    logic signed [15:0]       dry [2];
    smp_t                     wet [2];
    logic signed [IW+18:0]    acc [2];
    logic signed [IW+18:0]    accc [2];
    logic [IW+18:0]           absv [2];
    logic [46:0]              scl [2];
    logic [16:0]              dry_gain;

    assign en       = !ov_reg || m_ready;
    assign in_ready = en;
    assign dry_gain = 17'd65536 - mix;
    assign dry[0]   = dry_l;
    assign dry[1]   = dry_r;
    assign wet[0]   = wet_l;
    assign wet[1]   = wet_r;

    // clamp the mix sum, take its magnitude and scale it by 32767
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            acc[c]  = (IW+19)'(pd_reg[c]) + (IW+19)'(pw_reg[c]);
            accc[c] = acc[c];
            if (acc[c] > ACC_MAX) accc[c] = ACC_MAX;
            if (acc[c] < ACC_MIN) accc[c] = ACC_MIN;
            absv[c] = accc[c][IW+18] ? (IW+19)'(-accc[c]) : (IW+19)'(accc[c]);
            scl[c]  = 47'(mag_reg[c]) * 47'd32767;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= v3_reg;
        end
    end

    // advance the payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg <= last_in;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            lo_reg <= l3_reg;
            for (int c = 0; c < 2; c++) begin
                pd_reg[c]  <= dry[c] * $signed({1'b0, dry_gain});
                pw_reg[c]  <= wet[c] * $signed({1'b0, mix});
                mag_reg[c] <= absv[c][31:0];
                n2_reg[c]  <= accc[c][IW+18];
                sc_reg[c]  <= scl[c][46:31];
                n3_reg[c]  <= n2_reg[c];
                out_reg[c] <= n3_reg[c] ? -$signed(sc_reg[c]) : $signed(sc_reg[c]);
            end
        end
    end

    assign m_valid     = ov_reg;
    assign m_out_left  = out_reg[0];
    assign m_out_right = out_reg[1];
    assign m_block_end = lo_reg;

endmodule

`default_nettype wire

/* sv/stereo_comb_allpass_reverb.sv */
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb: stereo comb and allpass reverb
// Two channel lanes share one frame register and one mix stage; preset,
// decay and mix are held in an APB register bank.
// ----------------------------------------------------------------------------
//  channel  | ports                         | transfer
//  input    | s_in_left/right, s_block_last | s_valid & s_ready
//  result   | m_out_left/right, m_block_end | m_valid & m_ready
//  config   | psel/penable/pwrite/paddr     | write in access phase
//
//  A frame holds the lanes for eight steps, set by the four comb reads on
//  the single read port of each work store, and a handover in which the
//  next frame, waiting in the input register, starts. After the handover,
//  results pass the mix product, magnitude, scale and output registers.
//  After reset a clearing pass over all 16384 addresses zeroes all stores;
//  s_ready stays low meanwhile. A stalled result holds the whole mix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_comb_allpass_reverb
    import scar_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_in_left,
    input  wire logic signed [15:0] s_in_right,
    input  wire logic               s_block_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_left,
    output logic signed [15:0]      m_out_right,
    output logic                    m_block_end,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [1:0] REG_PRESET = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_MIX    = 2'd2;

    logic [2:0]          preset_reg;
    logic [16:0]         decay_reg;
    logic [16:0]         mix_reg;
    row_t                row_reg;
    logic [16:0]         fac_reg;
    logic [GAIN_W-1:0]   eff_reg;
    logic [16:0]         mixc_reg;

    logic                clr_active_reg;
    logic [WORK_AW-1:0]  clr_addr_reg;
    logic [WORK_AW-1:0]  pos_reg;

    logic                in_full_reg;
    logic signed [15:0]  in_l_reg;
    logic signed [15:0]  in_r_reg;
    logic                in_last_reg;
    logic                last_run_reg;

    clr_t                clr;
    lane_st_t            st_l, st_r;
    smp_t                wet_l, wet_r;
    logic signed [15:0]  dry_l, dry_r;
    logic                mix_ready;
    logic                take;
    logic                start;
    logic                wr_en;
    logic [2:0]          preset_c;
    logic [16:0]         decay_c;
    logic [31:0]         fac_prod;
    logic [32:0]         eff_prod;

    // register bank
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_reg <= 3'd4;
            decay_reg  <= 17'd45875;
            mix_reg    <= 17'd22938;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PRESET: preset_reg <= pwdata[2:0];
                REG_DECAY:  decay_reg  <= pwdata[16:0];
                REG_MIX:    mix_reg    <= pwdata[16:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PRESET: prdata = 32'(preset_reg);
            REG_DECAY:  prdata = 32'(decay_reg);
            REG_MIX:    prdata = 32'(mix_reg);
            default:    prdata = '0;
        endcase
    end

    // derive the effective wall gain over two stages
    assign preset_c = (preset_reg > 3'd5) ? 3'd5 : preset_reg;
    assign decay_c  = (decay_reg > 17'd65536) ? 17'd65536 : decay_reg;
    assign fac_prod = 32'(decay_c) * 32'd29491;
    assign eff_prod = 33'(row_reg.wall) * 33'(fac_reg);

    always_ff @(posedge aclk) begin
        row_reg  <= row_lookup(preset_c);
        fac_reg  <= 17'd32768 + 17'(fac_prod[31:16]);
        eff_reg  <= eff_prod[31:16];
        mixc_reg <= (mix_reg > 17'd65536) ? 17'd65536 : mix_reg;
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) clr_active_reg <= 1'b0;
        end
    end

    assign clr.active = clr_active_reg;
    assign clr.addr   = clr_addr_reg;

    // frame register and lane handover
    assign take    = st_l.done && st_r.done && mix_ready;
    assign start   = in_full_reg && (!st_l.busy || take);
    assign s_ready = !clr_active_reg && (!in_full_reg || start);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            if (s_valid && s_ready) in_full_reg <= 1'b1;
            else if (start)         in_full_reg <= 1'b0;
            if (start) pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_l_reg    <= s_in_left;
            in_r_reg    <= s_in_right;
            in_last_reg <= s_block_last;
        end
        if (start) last_run_reg <= in_last_reg;
    end

    scar_lane u_lane_l (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (clr),
        .start    (start),
        .take     (take),
        .dry_in   (in_l_reg),
        .pos      (pos_reg),
        .row      (row_reg),
        .eff_wall (eff_reg),
        .st       (st_l),
        .wet      (wet_l),
        .dry_out  (dry_l)
    );

    scar_lane u_lane_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (clr),
        .start    (start),
        .take     (take),
        .dry_in   (in_r_reg),
        .pos      (pos_reg),
        .row      (row_reg),
        .eff_wall (eff_reg),
        .st       (st_r),
        .wet      (wet_r),
        .dry_out  (dry_r)
    );

    scar_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (take),
        .in_ready    (mix_ready),
        .dry_l       (dry_l),
        .dry_r       (dry_r),
        .wet_l       (wet_l),
        .wet_r       (wet_r),
        .last_in     (last_run_reg),
        .mix         (mixc_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right),
        .m_block_end (m_block_end)
    );

    // no input transfer while the stores are being cleared
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("input accepted during clearing pass");

    // both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        st_l == st_r)
        else $error("channel lanes out of step");

    // each frame start advances the write position by one
    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("write position did not advance");

endmodule

`default_nettype wire

/* sim/tb_stereo_comb_allpass_reverb.sv */
// ----------------------------------------------------------------------------
// tb_stereo_comb_allpass_reverb: self-checking bench for the stereo reverb
// Drives stereo frames with random gaps, back-pressures the result side and
// compares every output frame with a bit-exact prediction of the lowpass,
// comb taps, allpass diffusers and dry/wet mix under several room settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stereo_comb_allpass_reverb;
    import scar_pkg::*;

    localparam logic [3:0] REG_PRESET = 4'd0;
    localparam logic [3:0] REG_DECAY  = 4'd4;
    localparam logic [3:0] REG_MIX    = 4'd8;
    localparam int WORK_N     = 16384;
    localparam int DIFF_N     = 2048;
    localparam int SETTLE     = 24;
    localparam int STALL_MAX  = 100000;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_res_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_in_left;
    logic signed [15:0] s_in_right;
    logic               s_block_last;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_out_left;
    logic signed [15:0] m_out_right;
    logic               m_block_end;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // room table: four comb delays, two allpass delays, wall gain in Q16
    int tap_tbl [6][4] = '{'{1500, 1600, 1700, 1800}, '{1200, 1300, 1400, 1500},
                           '{2000, 2200, 2400, 2600}, '{3000, 3300, 3600, 3900},
                           '{4000, 4400, 4800, 5200}, '{5500, 6000, 6500, 7000}};
    int ap1_tbl [6] = '{500, 400, 600, 800, 1000, 1200};
    int ap2_tbl [6] = '{400, 300, 500, 700, 900, 1100};
    int wall_tbl[6] = '{39322, 32768, 42598, 45875, 49152, 52429};

    // predictor state
    int work_mem [2][WORK_N];
    int diff_one [2][DIFF_N];
    int diff_two [2][DIFF_N];
    int lp_state [2];
    int wr_pos;
    logic [2:0]  cfg_preset;
    logic [16:0] cfg_decay;
    logic [16:0] cfg_mix;

    frame_res_t expected_frames[$];
    int  err_count;
    int  frames_sent;
    int  frames_checked;
    int  idle_cycles;
    bit  quiet;

    stereo_comb_allpass_reverb dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_left(s_in_left), .s_in_right(s_in_right), .s_block_last(s_block_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_left(m_out_left), .m_out_right(m_out_right), .m_block_end(m_block_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sat24(longint v);
        if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
        if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
        return v;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // one channel of the reverb; updates the predictor stores
    function automatic logic signed [15:0] reverb_lane(int ch, longint dry, int p,
                                                        longint eff, longint mix);
        int     di;
        longint sum, comb, d1, d2, out1, out2, filt, acc, mag;
        di   = wr_pos & (DIFF_N - 1);
        filt = sat24((longint'(lp_state[ch]) + dry) >>> 1);
        lp_state[ch] = int'(filt);
        sum = 0;
        for (int k = 0; k < 4; k++)
            sum += work_mem[ch][(wr_pos - tap_tbl[p][k]) & (WORK_N - 1)];
        comb = sum >>> 2;
        d1   = diff_one[ch][(di - ap1_tbl[p]) & (DIFF_N - 1)];
        out1 = sat24(d1 - comb);
        diff_one[ch][di] = int'(sat24(comb + (d1 >>> 1)));
        d2   = diff_two[ch][(di - ap2_tbl[p]) & (DIFF_N - 1)];
        out2 = sat24(d2 - out1);
        diff_two[ch][di] = int'(sat24(out1 + (d2 >>> 1)));
        work_mem[ch][wr_pos] = int'(sat24(filt + ((out2 * eff) >>> 16)));
        acc = dry * (64'sd65536 - mix) + out2 * mix;
        if (acc > (64'sd1 <<< 31)) acc = 64'sd1 <<< 31;
        if (acc < -(64'sd1 <<< 31)) acc = -(64'sd1 <<< 31);
        mag = (acc < 0) ? -acc : acc;
        mag = (mag * 32767) >>> 31;
        return 16'((acc < 0) ? -mag : mag);
    endfunction

    function automatic frame_res_t reverb_frame(logic signed [15:0] l, logic signed [15:0] r,
                                                logic last);
        frame_res_t res;
        int     p;
        longint dcy, mx, eff;
        p   = (cfg_preset > 3'd5) ? 5 : int'(cfg_preset);
        dcy = (cfg_decay > 17'd65536) ? 65536 : longint'(cfg_decay);
        mx  = (cfg_mix > 17'd65536) ? 65536 : longint'(cfg_mix);
        eff = (longint'(wall_tbl[p]) * (32768 + ((29491 * dcy) >>> 16))) >>> 16;
        res.left  = reverb_lane(0, longint'(l), p, eff, mx);
        res.right = reverb_lane(1, longint'(r), p, eff, mx);
        res.last  = last;
        wr_pos = (wr_pos + 1) & (WORK_N - 1);
        return res;
    endfunction

    // send one frame; called and returns at a falling edge
    task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_left    <= l;
        s_in_right   <= r;
        s_block_last <= last;
        do @(posedge aclk); while (!s_ready);
        expected_frames.push_back(reverb_frame(l, r, last));
        frames_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(int n, int loud_pct);
        logic signed [15:0] l, r;
        for (int i = 0; i < n; i++) begin
            l = 16'($urandom);
            r = 16'($urandom);
            if ($urandom_range(0, 99) < loud_pct) begin
                l = l[15] ? 16'sh8000 : 16'sh7fff;
                r = r[15] ? 16'sh8000 : 16'sh7fff;
            end
            send_frame(l, r, $urandom_range(0, 15) == 0);
        end
    endtask

    // wait until every frame is out, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // setup and access phases, then idle before returning
    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (addr)
            REG_PRESET: cfg_preset = data[2:0];
            REG_DECAY:  cfg_decay  = data[16:0];
            default:    cfg_mix    = data[16:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_room(logic [2:0] preset, logic [16:0] decay, logic [16:0] mix);
        drain();
        reg_write(REG_PRESET, 32'(preset));
        reg_write(REG_DECAY, 32'(decay));
        reg_write(REG_MIX, 32'(mix));
    endtask

    // sample extremes and frame marker under reset settings
    task automatic test_sample_extremes();
        logic signed [15:0] vals[8] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                        16'sh0001, 16'sh7fff, 16'sh8000, 16'sh5555};
        foreach (vals[i]) send_frame(vals[i], vals[7 - i], i[0]);
        for (int i = 0; i < 8; i++) send_frame(16'sh7fff, 16'sh8000, 1'b0);
    endtask

    // every preset row, out-of-range rows, and gain extremes
    task automatic test_presets_and_gains();
        for (int p = 0; p < 8; p++) begin
            set_room(p[2:0], (p % 3 == 0) ? 17'd0 : (p % 3 == 1) ? 17'd65536 : 17'h1ffff,
                     (p % 3 == 0) ? 17'd65536 : (p % 3 == 1) ? 17'd0 : 17'h1ffff);
            send_random(20, 40);
        end
    endtask

    // long random runs under random rooms; one run without idling
    task automatic test_random_rooms();
        for (int ph = 0; ph < 6; ph++) begin
            set_room(3'($urandom_range(0, 7)), 17'($urandom_range(0, 70000)),
                     17'($urandom_range(0, 70000)));
            quiet = (ph == 2);
            send_random(80, 10);
            drain();
            send_random(80, 10);
            quiet = 1'b0;
        end
        set_room(3'd5, 17'd65536, 17'd65536);
        send_random(70, 50);
    endtask

    // result side: random stall before each transfer
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        frame_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected result transfer");
                err_count++;
            end else begin
                e = expected_frames.pop_front();
                frames_checked++;
                if (m_out_left !== e.left) begin
                    $error("out_left expected %0d actual %0d", e.left, m_out_left);
                    err_count++;
                end
                if (m_out_right !== e.right) begin
                    $error("out_right expected %0d actual %0d", e.right, m_out_right);
                    err_count++;
                end
                if (m_block_end !== e.last) begin
                    $error("block_end expected %0d actual %0d", e.last, m_block_end);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_left = '0;
        s_in_right = '0;
        s_block_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_count = 0;
        frames_sent = 0;
        frames_checked = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        foreach (work_mem[c, i]) work_mem[c][i] = 0;
        foreach (diff_one[c, i]) begin
            diff_one[c][i] = 0;
            diff_two[c][i] = 0;
        end
        lp_state = '{0, 0};
        wr_pos = 0;
        cfg_preset = 3'd4;
        cfg_decay = 17'd45875;
        cfg_mix = 17'd22938;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_sample_extremes();
        test_presets_and_gains();
        test_random_rooms();
        drain();

        $display("Covered %0d frames, %0d checked, over all preset rows incl. out-of-range,",
                 frames_sent, frames_checked);
        $display("decay/mix at zero, one and above one, with random stalls on both sides.");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/scar_pkg.sv
sv/scar_lane.sv
sv/scar_mix.sv
sv/stereo_comb_allpass_reverb.sv
sim/tb_stereo_comb_allpass_reverb.sv
